// ===== rtl/radix2_fft_ifft_frame_defines.svh =====
// Assertion macros shared by the checker.
`ifndef RADIX2_FFT_IFFT_FRAME_DEFINES_SVH
`define RADIX2_FFT_IFFT_FRAME_DEFINES_SVH
// Assert that a property holds on every clock edge outside reset.
`define R2F_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Assert that a property holds on every clock edge, reset included.
`define R2F_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== rtl/r2fft_pkg.sv =====
// Package with shared types, constants and the twiddle table.
package r2fft_pkg;
  localparam int unsigned DataW = 24;
  localparam int unsigned RomLog2 = 6;

  localparam logic RegInverse = 1'b0;
  localparam logic RegSize = 1'b1;

  typedef logic signed [DataW-1:0] data_t;

  typedef struct packed {
    logic load;
    logic bfly_rd;
    logic bfly_wr;
    logic emit_rd;
  } dp_cmd_t;

  function automatic logic signed [16:0] quarter_cos(input logic [4:0] k);
    logic signed [16:0] v;
    unique case (k)
      5'd0: v = 17'sd32767;
      5'd1: v = 17'sd32610;
      5'd2: v = 17'sd32138;
      5'd3: v = 17'sd31357;
      5'd4: v = 17'sd30274;
      5'd5: v = 17'sd28899;
      5'd6: v = 17'sd27246;
      5'd7: v = 17'sd25330;
      5'd8: v = 17'sd23170;
      5'd9: v = 17'sd20788;
      5'd10: v = 17'sd18205;
      5'd11: v = 17'sd15447;
      5'd12: v = 17'sd12540;
      5'd13: v = 17'sd9512;
      5'd14: v = 17'sd6393;
      5'd15: v = 17'sd3212;
      default: v = 17'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [16:0] rom_cos(input logic [4:0] k);
    logic signed [16:0] r;
    if (k <= 5'd16) begin
      r = quarter_cos(k);
    end else begin
      r = -quarter_cos(5'(6'd32 - {1'b0, k}));
    end
    return r;
  endfunction

  function automatic logic signed [16:0] rom_sin(input logic [4:0] k);
    logic signed [16:0] r;
    if (k <= 5'd16) begin
      r = quarter_cos(5'(5'd16 - k));
    end else begin
      r = quarter_cos(5'(k - 5'd16));
    end
    return r;
  endfunction

  function automatic data_t sat24(input logic signed [DataW+1:0] v);
    data_t r;
    if (v[DataW+1:DataW-1] != 3'b000 && v[DataW+1:DataW-1] != 3'b111) begin
      r = v[DataW+1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction
endpackage

// ===== rtl/r2fft_ctrl.sv =====
// Controller state machine: frame loading, butterfly sequencing and bin output.
module r2fft_ctrl import r2fft_pkg::*; #(
  parameter int unsigned AddrW = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             cfg_hit,
  input  logic [2:0]       eff_log2,
  input  logic             out_free,
  output dp_cmd_t          cmd,
  output logic [AddrW-1:0] load_addr,
  output logic [AddrW-1:0] addr_p,
  output logic [AddrW-1:0] addr_q,
  output logic [4:0]       tw_k,
  output logic [AddrW-1:0] emit_addr,
  output logic             emit_last
);
  typedef enum logic [2:0] {
    S_LOAD, S_RD, S_MUL, S_WR, S_EMIT
  } state_t;

  state_t state;
  logic [AddrW:0] load_count;
  logic [AddrW:0] npts;
  logic [2:0] stage;
  logic [AddrW-1:0] bcount;
  logic [AddrW:0] ecount;
  logic [AddrW-1:0] half;
  logic [AddrW-1:0] nidx;
  logic [AddrW-1:0] rev;
  logic [AddrW-1:0] grp;
  logic load_go;
  logic emit_go;

  assign npts = (AddrW+1)'(1) << eff_log2;
  assign half = AddrW'((AddrW+1)'(1) << (stage - 3'd1));
  assign nidx = bcount & AddrW'(half - AddrW'(1));
  assign grp  = AddrW'((bcount & ~AddrW'(half - AddrW'(1))) << 1);
  assign addr_p = grp | nidx;
  assign addr_q = (grp | nidx) | half;
  assign tw_k = 5'((RomLog2+1)'(nidx) << (3'(RomLog2) - stage));

  always_comb begin
    rev = '0;
    for (int i = 0; i < AddrW; i++) begin
      if (i < int'(eff_log2)) begin
        rev[int'(eff_log2) - 1 - i] = load_count[i];
      end
    end
  end

  assign load_addr = rev;
  assign in_stall = (state != S_LOAD) || cfg_hit;
  assign load_go = (state == S_LOAD) && in_valid && !cfg_hit;
  assign emit_go = (state == S_EMIT) && out_free;
  assign emit_last = (ecount == npts - (AddrW+1)'(1));
  assign emit_addr = ecount[AddrW-1:0];

  always_comb begin
    cmd = '0;
    cmd.load = load_go;
    cmd.bfly_rd = (state == S_RD);
    cmd.bfly_wr = (state == S_WR);
    cmd.emit_rd = emit_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      load_count <= '0;
      stage <= 3'd1;
      bcount <= '0;
      ecount <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (cfg_hit) begin
            load_count <= '0;
          end else if (in_valid) begin
            if (load_count + (AddrW+1)'(1) == npts) begin
              load_count <= '0;
              stage <= 3'd1;
              bcount <= '0;
              state <= S_RD;
            end else begin
              load_count <= load_count + (AddrW+1)'(1);
            end
          end
        end
        S_RD: state <= S_MUL;
        S_MUL: state <= S_WR;
        S_WR: begin
          if ((AddrW+1)'(bcount) == (npts >> 1) - (AddrW+1)'(1)) begin
            bcount <= '0;
            if (stage == eff_log2) begin
              ecount <= '0;
              state <= S_EMIT;
            end else begin
              stage <= stage + 3'd1;
              state <= S_RD;
            end
          end else begin
            bcount <= bcount + AddrW'(1);
            state <= S_RD;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            if (emit_last) begin
              state <= S_LOAD;
            end
            ecount <= ecount + (AddrW+1)'(1);
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

// ===== rtl/r2fft_dp.sv =====
// Datapath: work memory, butterfly unit and output register.
module r2fft_dp import r2fft_pkg::*; #(
  parameter int unsigned AddrW = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  input  logic               inverse,
  input  logic [2:0]         eff_log2,
  input  logic [AddrW-1:0]   load_addr,
  input  logic [AddrW-1:0]   addr_p,
  input  logic [AddrW-1:0]   addr_q,
  input  logic [4:0]         tw_k,
  input  logic [AddrW-1:0]   emit_addr,
  input  logic               emit_last,
  input  logic signed [15:0] sample_re,
  input  logic signed [15:0] sample_im,
  input  logic               out_stall,
  output logic               out_valid,
  output logic               out_free,
  output data_t              bin_re,
  output data_t              bin_im,
  output logic               last_bin
);
  localparam int unsigned Depth = 1 << AddrW;
  logic [2*DataW-1:0] mem [Depth];
  logic [2*DataW-1:0] rd_p, rd_q;
  logic [AddrW-1:0] wa_p, wa_q;
  logic signed [16:0] c_r, s_r;
  logic signed [41:0] m_re, m_im;
  logic signed [42:0] t_re, t_im;
  logic signed [DataW+1:0] pr, pi;
  data_t ar, ai, br, bi;
  logic [0:0] emit_pipe;
  logic emit_last_q;
  data_t e_re;
  logic [AddrW-1:0] rd_a;
  logic [AddrW-1:0] wr_a;
  logic [2*DataW-1:0] wr_d;
  logic wr_en;
  logic [2*DataW-1:0] q_data;
  logic q_pend;
  logic [2*DataW-1:0] p_data;
  logic [2*DataW-1:0] mem_w2_d;
  logic [AddrW-1:0] mem_w2_a;
  logic mem_w2_en;

  assign rd_a = cmd.emit_rd ? emit_addr : addr_p;
  assign ar = rd_p[2*DataW-1:DataW];
  assign ai = rd_p[DataW-1:0];
  assign br = rd_q[2*DataW-1:DataW];
  assign bi = rd_q[DataW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_a] <= wr_d;
    end
    rd_p <= mem[rd_a];
    rd_q <= mem[addr_q];
  end

  always_comb begin
    wr_en = cmd.load || mem_w2_en;
    wr_a = cmd.load ? load_addr : mem_w2_a;
    wr_d = cmd.load ? {DataW'(sample_re), inverse ? DataW'(sample_im) : data_t'(0)}
                    : mem_w2_d;
  end

  // Butterfly: products registered in the middle cycle, second write sequential.
  always_ff @(posedge clk) begin
    c_r <= rom_cos(tw_k);
    s_r <= rom_sin(tw_k);
    wa_p <= addr_p;
    wa_q <= addr_q;
    if (inverse) begin
      m_re <= 42'(br) * 42'(c_r) - 42'(bi) * 42'(s_r);
      m_im <= 42'(bi) * 42'(c_r) + 42'(br) * 42'(s_r);
    end else begin
      m_re <= 42'(br) * 42'(c_r) + 42'(bi) * 42'(s_r);
      m_im <= 42'(bi) * 42'(c_r) - 42'(br) * 42'(s_r);
    end
  end

  assign t_re = (43'(m_re) + 43'sd16384) >>> 15;
  assign t_im = (43'(m_im) + 43'sd16384) >>> 15;
  assign pr = (DataW+2)'(t_re);
  assign pi = (DataW+2)'(t_im);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_pend <= 1'b0;
    end else begin
      q_pend <= cmd.bfly_wr;
    end
    if (cmd.bfly_wr) begin
      q_data <= {sat24((DataW+2)'(ar) - pr), sat24((DataW+2)'(ai) - pi)};
    end
  end

  // Both results share the write port: p first, then q in the next cycle.
  assign p_data = {sat24((DataW+2)'(ar) + pr), sat24((DataW+2)'(ai) + pi)};
  assign mem_w2_en = cmd.bfly_wr || q_pend;
  assign mem_w2_a = cmd.bfly_wr ? wa_p : wa_q;
  assign mem_w2_d = cmd.bfly_wr ? p_data : q_data;

  assign e_re = inverse ? data_t'(ar >>> eff_log2) : ar;

  assign out_free = !emit_pipe[0] && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_pipe <= '0;
      out_valid <= 1'b0;
    end else begin
      emit_pipe <= cmd.emit_rd;
      if (emit_pipe[0]) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (cmd.emit_rd) begin
      emit_last_q <= emit_last;
    end
    if (emit_pipe[0]) begin
      bin_re <= e_re;
      bin_im <= inverse ? data_t'(0) : ai;
      last_bin <= emit_last_q;
    end
  end
endmodule

// ===== rtl/radix2_fft_ifft_frame.sv =====
// Top level of the frame radix-2 FFT/IFFT with configuration port.
// Usage:
// Input channel (in_valid, in_stall, sample_re, sample_im) takes one sample
// per request; a frame of 2^size_log2 samples (size_log2 clamped to
// 1..log2 MAX_POINTS) is taken in natural order, stored bit-reversed, and
// the block then runs log2 N stages of butterflies, each through read,
// multiply and write states on one shared multiplier unit and the work memory.
// It then emits N bins on the output channel (out_valid, out_stall, bin_re,
// bin_im, last_bin), last_bin on the last; bin reads never overlap.
// Input stalls from the last sample of a frame until its last bin has issued.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are taken
// at once and restart frame loading; write only while the block is idle.
// A stalled output holds its request and the emit sequence waits.
// Reset selects forward mode with 64 points and clears the sample count.
module radix2_fft_ifft_frame import r2fft_pkg::*; #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] sample_re,
  input  logic signed [15:0] sample_im,
  output logic               out_valid,
  input  logic               out_stall,
  output data_t              bin_re,
  output data_t              bin_im,
  output logic               last_bin,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [2:0]         cfg_data
);
  localparam int unsigned AddrW = $clog2(MAX_POINTS + 1) - 1;
  localparam logic [2:0] MaxLog2 = 3'(AddrW);

  logic inverse;
  logic [2:0] size_log2;
  logic [2:0] eff_log2;
  logic cfg_hit;
  logic out_free;
  logic emit_last;
  dp_cmd_t cmd;
  logic [AddrW-1:0] load_addr, addr_p, addr_q, emit_addr;
  logic [4:0] tw_k;

  assign cfg_ready = 1'b1;
  assign cfg_hit = cfg_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      inverse <= 1'b0;
      size_log2 <= 3'd6;
    end else if (cfg_hit) begin
      unique case (cfg_index)
        RegInverse: inverse <= cfg_data[0];
        default: size_log2 <= cfg_data;
      endcase
    end
  end

  always_comb begin
    eff_log2 = size_log2;
    if (eff_log2 < 3'd1) begin
      eff_log2 = 3'd1;
    end
    if (eff_log2 > MaxLog2) begin
      eff_log2 = MaxLog2;
    end
  end

  r2fft_ctrl #(.AddrW(AddrW)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .cfg_hit, .eff_log2, .out_free,
    .cmd, .load_addr, .addr_p, .addr_q, .tw_k, .emit_addr, .emit_last
  );

  r2fft_dp #(.AddrW(AddrW)) u_dp (
    .clk, .rst, .cmd, .inverse, .eff_log2, .load_addr, .addr_p, .addr_q,
    .tw_k, .emit_addr, .emit_last, .sample_re, .sample_im,
    .out_stall, .out_valid, .out_free, .bin_re, .bin_im, .last_bin
  );
endmodule

// ===== rtl/r2fft_chk.sv =====
// Port checker for the frame FFT, bound to the top level.
`include "radix2_fft_ifft_frame_defines.svh"
module r2fft_chk import r2fft_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  in_stall,
  input logic  out_valid,
  input logic  out_stall,
  input data_t bin_re,
  input logic  last_bin
);
  `R2F_ASSERT(out_hold, out_valid && out_stall |=> out_valid && $stable(bin_re), "held bin changed")
  `R2F_ASSERT(no_in_while_out, out_valid && !last_bin |-> in_stall, "input open mid frame")
  `R2F_ASSERT(last_frees, out_valid && !out_stall && last_bin |=> !out_valid, "bin after last")
  `R2F_ASSERT_ALWAYS(rst_quiet, rst |=> !out_valid, "output valid after reset")
endmodule

bind radix2_fft_ifft_frame r2fft_chk u_chk (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .bin_re, .last_bin
);
